// ===== hdl/crr_pkg.sv =====
`default_nettype none
package crr_pkg;

	localparam int MAX_ROUNDS = 32;
	localparam int RIDX_W     = 5;
	localparam int CNT_W      = 6;
	localparam int BLK_W      = 64;
	localparam int NIB        = 16;

	typedef enum logic [1:0] {
		REG_KEY_ZERO    = 2'd0,
		REG_KEY_ONE     = 2'd1,
		REG_ROUND_COUNT = 2'd2
	} reg_idx_t;

	// configuration seen by every round cell
	typedef struct packed {
		logic [BLK_W-1:0] key_zero;
		logic [BLK_W-1:0] key_one;
		logic [CNT_W-1:0] rounds;
	} cfg_t;

	// data handed from cell to cell
	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic [BLK_W-1:0] twk;
	} lane_t;

	localparam logic [3:0] SBOX [NIB] = '{
		4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
		4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6};
	localparam logic [3:0] PERM [NIB] = '{
		4'hf, 4'hc, 4'hd, 4'he, 4'ha, 4'h9, 4'h8, 4'hb,
		4'h6, 4'h5, 4'h4, 4'h7, 4'h1, 4'h2, 4'h3, 4'h0};
	localparam logic [3:0] TPERM [NIB] = '{
		4'hc, 4'ha, 4'hf, 4'h5, 4'he, 4'h8, 4'h9, 4'h2,
		4'hb, 4'h3, 4'h7, 4'h4, 4'h6, 4'h0, 4'h1, 4'hd};
	localparam logic [3:0] RC_THREE [MAX_ROUNDS] = '{
		4'h1, 4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1,
		4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4,
		4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2,
		4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2, 4'h5};
	localparam logic [3:0] RC_FOUR [MAX_ROUNDS] = '{
		4'h1, 4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb,
		4'h5, 4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1,
		4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb, 4'h5,
		4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1, 4'h8};

	// nibble 0 sits in the top four bits
	function automatic logic [3:0] get_nib(input logic [BLK_W-1:0] v, input int i);
		return v[BLK_W-1-4*i -: 4];
	endfunction

	// q(t)[i] = t[tperm[i]]
	function automatic logic [BLK_W-1:0] tweak_perm(input logic [BLK_W-1:0] t);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < NIB; i++) begin
			r[BLK_W-1-4*i -: 4] = get_nib(t, int'(TPERM[i]));
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] mix_columns(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] r;
		r = s;
		for (int i = 0; i < 4; i++) begin
			r[BLK_W-1-4*i -: 4] = get_nib(s, i) ^ get_nib(s, i + 8) ^ get_nib(s, i + 12);
			r[BLK_W-1-4*(i+4) -: 4] = get_nib(s, i + 4) ^ get_nib(s, i + 12);
		end
		return r;
	endfunction

	// out[perm[i]] = in[i], then the s-box on every nibble
	function automatic logic [BLK_W-1:0] perm_sub(input logic [BLK_W-1:0] s);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < NIB; i++) begin
			r[BLK_W-1-4*int'(PERM[i]) -: 4] = SBOX[get_nib(s, i)];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/crr_round_cell.sv =====
`default_nettype none
module crr_round_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire crr_pkg::cfg_t             cfg,
	input  wire logic [crr_pkg::RIDX_W-1:0] round_idx,
	input  wire logic                      up_valid,
	output logic                           up_ready,
	input  wire crr_pkg::lane_t            up_data,
	output logic                           down_valid,
	input  wire logic                      down_ready,
	output crr_pkg::lane_t                 down_data
);

	logic                          valid_q;
	crr_pkg::lane_t                data_q;
	logic                          active;
	logic [crr_pkg::BLK_W-1:0]     tweakey;
	logic [crr_pkg::BLK_W-1:0]     mixed;
	logic [crr_pkg::BLK_W-1:0]     keyed;
	crr_pkg::lane_t                data_d;

	assign up_ready   = !valid_q || down_ready;
	assign down_valid = valid_q;
	assign down_data  = data_q;

	// rounds past the configured count pass the block through
	assign active = {1'b0, round_idx} < cfg.rounds;

	// tweakey r mod 4: bit 0 picks the key half, bit 1 the permuted tweak
	assign tweakey = (round_idx[0] ? cfg.key_one : cfg.key_zero)
		^ (round_idx[1] ? crr_pkg::tweak_perm(up_data.twk) : up_data.twk);

	always_comb begin
		mixed = crr_pkg::mix_columns(up_data.blk);
		mixed[crr_pkg::BLK_W-17 -: 4] = mixed[crr_pkg::BLK_W-17 -: 4]
			^ crr_pkg::RC_FOUR[round_idx];
		mixed[crr_pkg::BLK_W-21 -: 4] = mixed[crr_pkg::BLK_W-21 -: 4]
			^ crr_pkg::RC_THREE[round_idx];
		keyed      = mixed ^ tweakey;
		data_d.twk = up_data.twk;
		data_d.blk = active ? crr_pkg::perm_sub(keyed) : up_data.blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= data_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/craft_reduced_round_encrypt_top.sv =====
`default_nettype none
// craft encryption engine, 64-bit block and 64-bit tweak, with a configurable
// number of full rounds (1 to 32; 0 gives the plaintext back, a six-bit count
// above 32 acts as 32). it is a row of 32 round cells, one per round, each
// registering one item and passing it on, so one item is taken per clock while
// the output is not stalled; its ciphertext leaves the last cell. every
// cell applies its round only if its index is below the configured count,
// so every item crosses all 32 cells whatever round_count holds. each cell forms its
// own tweakey from the key registers and the tweak that travels with the
// block. a stalled output backs up only as far as needed: empty cells keep
// accepting. write key_zero, key_one and round_count only while the engine
// holds no item.
module craft_reduced_round_encrypt_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration write port
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [crr_pkg::BLK_W-1:0]  cfg_data,
	// input items
	input  wire logic                       item_valid,
	output logic                            item_ready,
	input  wire logic [crr_pkg::BLK_W-1:0]  plain_block,
	input  wire logic [crr_pkg::BLK_W-1:0]  tweak_block,
	// result items
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output logic [crr_pkg::BLK_W-1:0]       cipher_block
);

	localparam int N = crr_pkg::MAX_ROUNDS;

	crr_pkg::cfg_t   cfg_q;
	logic            chain_valid [N+1];
	logic            chain_ready [N+1];
	crr_pkg::lane_t  chain_data  [N+1];

	// config registers; round count is masked to six bits and saturated here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_zero <= '0;
			cfg_q.key_one  <= '0;
			cfg_q.rounds   <= crr_pkg::CNT_W'(N);
		end else if (cfg_we) begin
			case (cfg_index)
				crr_pkg::REG_KEY_ZERO:    cfg_q.key_zero <= cfg_data;
				crr_pkg::REG_KEY_ONE:     cfg_q.key_one  <= cfg_data;
				crr_pkg::REG_ROUND_COUNT: begin
					if (cfg_data[crr_pkg::CNT_W-1:0] > crr_pkg::CNT_W'(N)) begin
						cfg_q.rounds <= crr_pkg::CNT_W'(N);
					end else begin
						cfg_q.rounds <= cfg_data[crr_pkg::CNT_W-1:0];
					end
				end
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// head of the chain
	assign chain_valid[0]    = item_valid;
	assign item_ready        = chain_ready[0];
	assign chain_data[0].blk = plain_block;
	assign chain_data[0].twk = tweak_block;

	for (genvar g = 0; g < N; g++) begin : g_cell
		crr_round_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg        (cfg_q),
			.round_idx  (crr_pkg::RIDX_W'(g)),
			.up_valid   (chain_valid[g]),
			.up_ready   (chain_ready[g]),
			.up_data    (chain_data[g]),
			.down_valid (chain_valid[g+1]),
			.down_ready (chain_ready[g+1]),
			.down_data  (chain_data[g+1])
		);
	end

	// tail of the chain: last cell register drives the result directly
	assign result_valid   = chain_valid[N];
	assign chain_ready[N] = result_ready;
	assign cipher_block   = chain_data[N].blk;

endmodule
`default_nettype wire

// ===== hdl/crr_checker.sv =====
`default_nettype none
module crr_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cfg_we,
	input wire logic [1:0]                cfg_index,
	input wire logic [crr_pkg::BLK_W-1:0] cfg_data,
	input wire logic                      item_valid,
	input wire logic                      item_ready,
	input wire logic [crr_pkg::BLK_W-1:0] plain_block,
	input wire logic [crr_pkg::BLK_W-1:0] tweak_block,
	input wire logic                      result_valid,
	input wire logic                      result_ready,
	input wire logic [crr_pkg::BLK_W-1:0] cipher_block
);

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(cipher_block))
		else $error("result changed while stalled");

	// an output that is empty or draining never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("input stalled with output free");

	// reset empties the cell chain
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result offered during reset");

endmodule

bind craft_reduced_round_encrypt_top crr_checker u_crr_checker (.*);
`default_nettype wire

// ===== verif/craft_cipher_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module craft_cipher_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [crr_pkg::BLK_W-1:0]  cfg_data,
	input  wire logic                       item_valid,
	input  wire logic                       item_ready,
	input  wire logic [crr_pkg::BLK_W-1:0]  plain_block,
	input  wire logic [crr_pkg::BLK_W-1:0]  tweak_block,
	input  wire logic                       result_valid,
	input  wire logic                       result_ready,
	input  wire logic [crr_pkg::BLK_W-1:0]  cipher_block,
	output int                              cipher_pending,
	output int                              mismatch_count
);

	// tables packed a nibble per entry (16 or 32 to a word), entry 0 in the top bits
	localparam logic [63:0]  SUB_NIBS   = 64'hcad3ebf789150246;
	localparam logic [63:0]  STATE_ORD  = 64'hfcdea98b65471230;
	localparam logic [63:0]  TWEAK_ORD  = 64'hcaf5e892b374601d;
	localparam logic [127:0] CONST_LO   = 128'h1425673142567314_2567314256731425;
	localparam logic [127:0] CONST_HI   = 128'h18429c6b5adef731_8429c6b5adef7318;

	logic [crr_pkg::BLK_W-1:0] key_zero_q;
	logic [crr_pkg::BLK_W-1:0] key_one_q;
	logic [crr_pkg::CNT_W-1:0] rounds_q;
	logic [crr_pkg::BLK_W-1:0] cipher_q [$];
	logic [crr_pkg::BLK_W-1:0] expected;
	int                        errs = 0;

	function automatic logic [3:0] nib(input logic [63:0] v, input int i);
		return v[63-4*i -: 4];
	endfunction

	function automatic logic [crr_pkg::BLK_W-1:0] craft_encrypt(
			input logic [crr_pkg::BLK_W-1:0] blk,
			input logic [crr_pkg::BLK_W-1:0] twk, input logic [crr_pkg::BLK_W-1:0] k0,
			input logic [crr_pkg::BLK_W-1:0] k1, input logic [crr_pkg::CNT_W-1:0] rc);
		logic [3:0]                st [16];
		logic [3:0]                tmp [16];
		logic [crr_pkg::BLK_W-1:0] tq;
		logic [crr_pkg::BLK_W-1:0] tk [4];
		logic [crr_pkg::BLK_W-1:0] res;
		int                        nr;
		for (int i = 0; i < 16; i++) begin
			tq[63-4*i -: 4] = nib(twk, int'(nib(TWEAK_ORD, i)));
			st[i] = nib(blk, i);
		end
		tk[0] = k0 ^ twk;
		tk[1] = k1 ^ twk;
		tk[2] = k0 ^ tq;
		tk[3] = k1 ^ tq;
		// counts above the top saturate
		nr = (int'(rc) > crr_pkg::MAX_ROUNDS) ? crr_pkg::MAX_ROUNDS : int'(rc);
		for (int r = 0; r < nr; r++) begin
			for (int i = 0; i < 4; i++) begin
				st[i] = st[i] ^ st[i+8] ^ st[i+12];
				st[i+4] = st[i+4] ^ st[i+12];
			end
			st[4] = st[4] ^ CONST_HI[127-4*r -: 4];
			st[5] = st[5] ^ CONST_LO[127-4*r -: 4];
			for (int i = 0; i < 16; i++)
				st[i] = st[i] ^ nib(tk[r % 4], i);
			for (int i = 0; i < 16; i++)
				tmp[int'(nib(STATE_ORD, i))] = st[i];
			for (int i = 0; i < 16; i++)
				st[i] = nib(SUB_NIBS, int'(tmp[i]));
		end
		for (int i = 0; i < 16; i++)
			res[63-4*i -: 4] = st[i];
		return res;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			key_zero_q = '0;
			key_one_q = '0;
			rounds_q = crr_pkg::CNT_W'(crr_pkg::MAX_ROUNDS);
			cipher_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					crr_pkg::REG_KEY_ZERO:    key_zero_q = cfg_data;
					crr_pkg::REG_KEY_ONE:     key_one_q = cfg_data;
					crr_pkg::REG_ROUND_COUNT: rounds_q = cfg_data[crr_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				cipher_q.push_back(craft_encrypt(plain_block, tweak_block,
					key_zero_q, key_one_q, rounds_q));
			if (result_valid && result_ready) begin
				if (cipher_q.size() == 0) begin
					$error("cipher_block: expected none, actual %h", cipher_block);
					errs++;
				end else begin
					expected = cipher_q.pop_front();
					if (cipher_block !== expected) begin
						$error("cipher_block: expected %h, actual %h", expected, cipher_block);
						errs++;
					end
				end
			end
		end
		cipher_pending <= cipher_q.size();
		mismatch_count <= errs;
	end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	// index past the last register, writes to it must be dropped
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         PIPE_DEPTH  = 32;
	localparam int         STALL_LIMIT = 2000;
	localparam int         PHASES      = 8;
	localparam int         PHASE_ITEMS = 180;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [1:0]                cfg_index = '0;
	logic [crr_pkg::BLK_W-1:0] cfg_data = '0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	logic [crr_pkg::BLK_W-1:0] plain_block = '0;
	logic [crr_pkg::BLK_W-1:0] tweak_block = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic [crr_pkg::BLK_W-1:0] cipher_block;

	// calm turns off idling on both sides
	logic             calm = 1'b0;
	int               cipher_pending;
	int               mismatch_count;
	int               stuck_cycles = 0;

	craft_reduced_round_encrypt_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.plain_block  (plain_block),
		.tweak_block  (tweak_block),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cipher_block (cipher_block)
	);

	craft_cipher_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.plain_block    (plain_block),
		.tweak_block    (tweak_block),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.cipher_block   (cipher_block),
		.cipher_pending (cipher_pending),
		.mismatch_count (mismatch_count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stalls at random, with a chance of 9 in 100 unless calm
	always @(posedge clk) begin
		result_ready <= calm || ($urandom_range(99) >= 9);
	end

	// watchdog on cycles where nothing moves on any port
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (item_valid && item_ready) || (result_valid && result_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [crr_pkg::BLK_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly random words, now and then all zeros or all ones
	function automatic logic [crr_pkg::BLK_W-1:0] pick_word();
		case ($urandom_range(19))
			0:       return '0;
			1:       return '1;
			default: return rand64();
		endcase
	endfunction

	// round count register data, with the extremes weighted up and junk above bit 5
	function automatic logic [crr_pkg::BLK_W-1:0] pick_rounds();
		logic [crr_pkg::BLK_W-1:0] d;
		case ($urandom_range(9))
			0:       d = 0;
			1:       d = 1;
			2:       d = crr_pkg::MAX_ROUNDS;
			3:       d = $urandom_range(63, crr_pkg::MAX_ROUNDS + 1);
			default: d = $urandom_range(crr_pkg::MAX_ROUNDS, 1);
		endcase
		if ($urandom_range(3) == 0)
			d[crr_pkg::BLK_W-1:crr_pkg::CNT_W] = (crr_pkg::BLK_W-crr_pkg::CNT_W)'(rand64());
		return d;
	endfunction

	// one input item, with a random gap in front unless calm
	task automatic send_block(input logic [crr_pkg::BLK_W-1:0] p,
			input logic [crr_pkg::BLK_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 9)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		plain_block <= p;
		tweak_block <= t;
		do @(posedge clk); while (!item_ready);
	endtask

	// stop sending and wait until every ciphertext is back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (cipher_pending != 0) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [crr_pkg::BLK_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [crr_pkg::BLK_W-1:0] k0,
			input logic [crr_pkg::BLK_W-1:0] k1, input logic [crr_pkg::BLK_W-1:0] rc);
		write_reg(crr_pkg::REG_KEY_ZERO, k0);
		write_reg(crr_pkg::REG_KEY_ONE, k1);
		write_reg(crr_pkg::REG_ROUND_COUNT, rc);
		cfg_we <= 1'b0;
	endtask

	task automatic set_rounds(input logic [crr_pkg::BLK_W-1:0] rc);
		write_reg(crr_pkg::REG_ROUND_COUNT, rc);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero keys, full 32 rounds
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210);

		// all-ones keys at full rounds, tweak extremes on their own
		drain();
		set_config('1, '1, crr_pkg::MAX_ROUNDS);
		send_block('0, '0);
		send_block('1, '0);
		send_block('0, '1);

		// zero rounds hands the plaintext back
		drain();
		set_config(rand64(), rand64(), 0);
		send_block(rand64(), rand64());
		send_block('1, rand64());

		// a single round
		drain();
		set_config(rand64(), rand64(), 1);
		send_block(rand64(), rand64());
		send_block(rand64(), '1);

		// counts past the top saturate, one of them with every data bit set
		drain();
		set_rounds(crr_pkg::MAX_ROUNDS + 1);
		send_block(rand64(), rand64());
		send_block(rand64(), rand64());
		drain();
		set_rounds('1);
		send_block(rand64(), rand64());
		send_block(rand64(), rand64());

		// write to the unused index must leave everything as it was
		drain();
		write_reg(REG_UNUSED, rand64());
		cfg_we <= 1'b0;
		send_block(rand64(), rand64());
		send_block(rand64(), rand64());

		// bits above the count field are dropped
		drain();
		set_rounds(64'hffff_ffff_ffff_ffc2);
		send_block(rand64(), rand64());
		drain();
		set_rounds(crr_pkg::MAX_ROUNDS - 1);
		send_block(rand64(), rand64());

		// random phases, each under its own setting; phase 3 runs with no idling
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if ($urandom_range(2) == 0)
				write_reg(REG_UNUSED, rand64());
			set_config(pick_word(), pick_word(), pick_rounds());
			calm <= (ph == 3);
			repeat (PHASE_ITEMS) send_block(pick_word(), pick_word());
		end

		// let the row of round cells empty out, then give it a little longer
		drain();
		calm <= 1'b0;
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && cipher_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
